// File: rtl/core/pspb_pkg.sv
// package: shared types and constants of the palette sprite blitter
`timescale 1ns / 1ps
`default_nettype none

package pspb_pkg;

	localparam int MAX_DIM_DEF     = 128;
	localparam int STORE_BYTES_DEF = 8192;
	localparam int PALETTE_SIZE    = 16;
	localparam int PAL_AW          = $clog2(PALETTE_SIZE);
	localparam int LIN_W           = 16;

	localparam logic [7:0] NIBBLE_MASK = 8'h0F;

	localparam logic [2:0] REQ_LOAD_PIXEL   = 3'd0;
	localparam logic [2:0] REQ_LOAD_PALETTE = 3'd1;
	localparam logic [2:0] REQ_DRAW         = 3'd2;
	localparam logic [2:0] REQ_SHADOW_DRAW  = 3'd3;
	localparam logic [2:0] REQ_MOVE_CLEAR   = 3'd4;

	localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [2:0] REG_ORIGIN_X     = 3'd2;
	localparam logic [2:0] REG_ORIGIN_Y     = 3'd3;
	localparam logic [2:0] REG_MOVE_DX      = 3'd4;
	localparam logic [2:0] REG_MOVE_DY      = 3'd5;
	localparam logic [2:0] REG_CLEAR_COLOR  = 3'd6;
	localparam logic [2:0] REG_SHADOW_COLOR = 3'd7;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [6:0]  column;
		logic [6:0]  row;
		logic [12:0] pixel_byte_addr;
		logic [7:0]  pixel_byte;
		logic [3:0]  palette_slot;
		logic [15:0] palette_color;
	} pspb_in_t;

	typedef struct packed {
		logic               write_enable;
		logic signed [15:0] screen_x;
		logic signed [15:0] screen_y;
		logic [15:0]        color;
	} pspb_out_t;

endpackage

`default_nettype wire

// File: rtl/core/pspb_pixel_mem.sv
// pixel byte memory: one write port, two registered read ports
`timescale 1ns / 1ps
`default_nettype none

module pspb_pixel_mem #(
	parameter int DEPTH = 8192,
	parameter int AW    = 13
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr0,
	input  wire logic [AW-1:0] raddr1,
	output logic      [7:0]    rdata0,
	output logic      [7:0]    rdata1
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/palette_sprite_pixel_blit.sv
// top level: palettized 4bpp sprite blitter with draw, shadow draw and move clear
// throughput: one item per cycle while res_ready does not stall the output; stages are
// the input register, address calc, pixel memory read, palette read and the output
// register, each holding its beat on a stall
// reset: clears all valid bits and the config registers (width and height 1, rest 0);
// pixel memory and palette are not cleared and hold garbage until loaded
`timescale 1ns / 1ps
`default_nettype none

module palette_sprite_pixel_blit #(
	parameter int MAX_DIM     = pspb_pkg::MAX_DIM_DEF,
	parameter int STORE_BYTES = pspb_pkg::STORE_BYTES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire pspb_pkg::pspb_in_t req,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output pspb_pkg::pspb_out_t     res,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data
);

	import pspb_pkg::*;

	localparam int SA_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

	// config registers
	logic [7:0]  eff_w_q, eff_h_q;
	logic [15:0] origin_x_q, origin_y_q, move_dx_q, move_dy_q;
	logic [15:0] clear_color_q, shadow_color_q;

	function automatic logic [7:0] clamp_dim(input logic [7:0] d);
		logic [7:0] r;
		r = ({24'd0, d} > 32'(MAX_DIM)) ? 8'(MAX_DIM) : d;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q        <= 8'd1;
			eff_h_q        <= 8'd1;
			origin_x_q     <= '0;
			origin_y_q     <= '0;
			move_dx_q      <= '0;
			move_dy_q      <= '0;
			clear_color_q  <= '0;
			shadow_color_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  eff_w_q        <= clamp_dim(cfg_data[7:0]);
				REG_IMAGE_HEIGHT: eff_h_q        <= clamp_dim(cfg_data[7:0]);
				REG_ORIGIN_X:     origin_x_q     <= cfg_data;
				REG_ORIGIN_Y:     origin_y_q     <= cfg_data;
				REG_MOVE_DX:      move_dx_q      <= cfg_data;
				REG_MOVE_DY:      move_dy_q      <= cfg_data;
				REG_CLEAR_COLOR:  clear_color_q  <= cfg_data;
				REG_SHADOW_COLOR: shadow_color_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage enables, bubbles collapse
	logic valid_s1, valid_s2, valid_s3, valid_s4, res_valid_q;
	logic en1, en2, en3, en4, en5;

	assign en5       = !res_valid_q || res_ready;
	assign en4       = !valid_s4 || en5;
	assign en3       = !valid_s3 || en4;
	assign en2       = !valid_s2 || en3;
	assign en1       = !valid_s1 || en2;
	assign req_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (en1) valid_s1 <= req_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
			if (en5) res_valid_q <= valid_s4;
		end
	end

	// stage 1: input beat and shifted coordinates
	pspb_in_t    req_s1;
	logic [16:0] col2_s1, row2_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			req_s1  <= req;
			col2_s1 <= {10'd0, req.column} - {move_dx_q[15], move_dx_q};
			row2_s1 <= {10'd0, req.row} - {move_dy_q[15], move_dy_q};
		end
	end

	// stage 1 to 2: bounds and linear pixel index
	logic             in1_c, in2_c;
	logic [LIN_W-1:0] lin1_c, lin2_c;
	logic [31:0]      bidx1_c, bidx2_c, ldaddr_c;

	always_comb begin
		in1_c = ({1'b0, req_s1.column} < eff_w_q) && ({1'b0, req_s1.row} < eff_h_q);
		in2_c = !col2_s1[16] && (col2_s1[15:0] < {8'd0, eff_w_q})
			&& !row2_s1[16] && (row2_s1[15:0] < {8'd0, eff_h_q});
		lin1_c = LIN_W'({9'd0, req_s1.row}) * LIN_W'(eff_w_q) + LIN_W'(req_s1.column);
		lin2_c = LIN_W'(row2_s1[7:0]) * LIN_W'(eff_w_q) + LIN_W'(col2_s1[7:0]);
		bidx1_c  = 32'(lin1_c[LIN_W-1:1]);
		bidx2_c  = 32'(lin2_c[LIN_W-1:1]);
		ldaddr_c = 32'(req_s1.pixel_byte_addr);
	end

	logic [2:0]      req_type_s2;
	logic            in1_s2, in2_s2, odd1_s2, odd2_s2, store1_s2, store2_s2;
	logic [SA_W-1:0] addr1_s2, addr2_s2, ld_addr_s2;
	logic            ld_ok_s2;
	logic [7:0]      pixel_byte_s2;
	logic [3:0]      slot_s2;
	logic [15:0]     pcolor_s2, sx_s2, sy_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			req_type_s2   <= req_s1.req_type;
			in1_s2        <= in1_c;
			in2_s2        <= in2_c;
			odd1_s2       <= lin1_c[0];
			odd2_s2       <= lin2_c[0];
			store1_s2     <= bidx1_c < 32'(STORE_BYTES);
			store2_s2     <= bidx2_c < 32'(STORE_BYTES);
			addr1_s2      <= bidx1_c[SA_W-1:0];
			addr2_s2      <= bidx2_c[SA_W-1:0];
			ld_addr_s2    <= ldaddr_c[SA_W-1:0];
			ld_ok_s2      <= ldaddr_c < 32'(STORE_BYTES);
			pixel_byte_s2 <= req_s1.pixel_byte;
			slot_s2       <= req_s1.palette_slot;
			pcolor_s2     <= req_s1.palette_color;
			sx_s2         <= origin_x_q + 16'(req_s1.column);
			sy_s2         <= origin_y_q + 16'(req_s1.row);
		end
	end

	// stage 2 to 3: pixel memory, loads written at the same point queries read
	logic [7:0] rd1_s3, rd2_s3;

	pspb_pixel_mem #(
		.DEPTH (STORE_BYTES),
		.AW    (SA_W)
	) u_pixel_mem (
		.clk    (clk),
		.we     (en2 && valid_s2 && (req_type_s2 == REQ_LOAD_PIXEL) && ld_ok_s2),
		.waddr  (ld_addr_s2),
		.wdata  (pixel_byte_s2),
		.re     (en3),
		.raddr0 (addr1_s2),
		.raddr1 (addr2_s2),
		.rdata0 (rd1_s3),
		.rdata1 (rd2_s3)
	);

	logic [2:0]  req_type_s3;
	logic        in1_s3, in2_s3, odd1_s3, odd2_s3, store1_s3, store2_s3;
	logic [3:0]  slot_s3;
	logic [15:0] pcolor_s3, sx_s3, sy_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			req_type_s3 <= req_type_s2;
			in1_s3      <= in1_s2;
			in2_s3      <= in2_s2;
			odd1_s3     <= odd1_s2;
			odd2_s3     <= odd2_s2;
			store1_s3   <= store1_s2;
			store2_s3   <= store2_s2;
			slot_s3     <= slot_s2;
			pcolor_s3   <= pcolor_s2;
			sx_s3       <= sx_s2;
			sy_s3       <= sy_s2;
		end
	end

	// stage 3 to 4: nibble select and palette lookup
	logic [7:0]        nb1_c, nb2_c;
	logic [PAL_AW-1:0] nib1_c, nib2_c;

	always_comb begin
		nb1_c  = odd1_s3 ? (rd1_s3 & NIBBLE_MASK) : ((rd1_s3 >> 4) & NIBBLE_MASK);
		nb2_c  = odd2_s3 ? (rd2_s3 & NIBBLE_MASK) : ((rd2_s3 >> 4) & NIBBLE_MASK);
		nib1_c = store1_s3 ? nb1_c[PAL_AW-1:0] : '0;
		nib2_c = store2_s3 ? nb2_c[PAL_AW-1:0] : '0;
	end

	logic [15:0] pal_q [PALETTE_SIZE];
	logic [15:0] pc1_s4, pc2_s4, p0_s4, sx_s4, sy_s4;
	logic [2:0]  req_type_s4;
	logic        in1_s4, in2_s4;

	always_ff @(posedge clk) begin
		if (en3) begin
			if (valid_s3 && (req_type_s3 == REQ_LOAD_PALETTE)) begin
				pal_q[slot_s3[PAL_AW-1:0]] <= pcolor_s3;
			end
		end
		if (en4) begin
			pc1_s4      <= pal_q[nib1_c];
			pc2_s4      <= pal_q[nib2_c];
			p0_s4       <= pal_q[0];
			req_type_s4 <= req_type_s3;
			in1_s4      <= in1_s3;
			in2_s4      <= in2_s3;
			sx_s4       <= sx_s3;
			sy_s4       <= sy_s3;
		end
	end

	// stage 4 to output: transparency test and result beat
	pspb_out_t res_c;
	logic      opaque1_c, clear2_c;

	always_comb begin
		opaque1_c = in1_s4 && (pc1_s4 != p0_s4);
		clear2_c  = !in2_s4 || (pc2_s4 == p0_s4);
		res_c     = '0;
		case (req_type_s4)
			REQ_DRAW: begin
				res_c.write_enable = opaque1_c;
				res_c.color        = pc1_s4;
			end
			REQ_SHADOW_DRAW: begin
				res_c.write_enable = opaque1_c;
				res_c.color        = shadow_color_q;
			end
			REQ_MOVE_CLEAR: begin
				res_c.write_enable = opaque1_c && clear2_c;
				res_c.color        = clear_color_q;
			end
			default: res_c.write_enable = 1'b0;
		endcase
		if (res_c.write_enable) begin
			res_c.screen_x = sx_s4;
			res_c.screen_y = sy_s4;
		end else begin
			res_c = '0;
		end
	end

	pspb_out_t res_q;

	always_ff @(posedge clk) begin
		if (en5) begin
			res_q <= res_c;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

// File: bench/blit_checker.sv
// checker for the palette sprite blitter: predicts each result beat and compares it
`timescale 1ns / 1ps

module blit_checker
	import pspb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	input  wire logic        req_ready,
	input  wire pspb_in_t    req,
	input  wire logic        res_valid,
	input  wire logic        res_ready,
	input  wire pspb_out_t   res,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	output int               mismatches,
	output int               outstanding,
	output int               beats_checked,
	output int               writes_seen
);

	logic [7:0]         sprite_mem [STORE_BYTES_DEF];
	logic [15:0]        clut [PALETTE_SIZE];
	logic [7:0]         img_w = 8'd1;
	logic [7:0]         img_h = 8'd1;
	logic [15:0]        org_x = '0;
	logic [15:0]        org_y = '0;
	logic signed [15:0] shift_x = '0;
	logic signed [15:0] shift_y = '0;
	logic [15:0]        clr_color = '0;
	logic [15:0]        shd_color = '0;
	pspb_out_t          expected_writes [$];
	pspb_out_t          want;

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] exp_val);
		$display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, exp_val);
		mismatches++;
	endtask

	// palette color of an image pixel; on_img is cleared when the pixel is off the image
	function automatic logic [15:0] texel(input int c, input int r, output bit on_img);
		int w;
		int h;
		int lin;
		logic [7:0] b;
		w = (img_w > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(img_w);
		h = (img_h > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(img_h);
		if (c < 0 || r < 0 || c >= w || r >= h) begin
			on_img = 1'b0;
			return clut[0];
		end
		on_img = 1'b1;
		lin = r * w + c;
		if ((lin >> 1) >= STORE_BYTES_DEF) begin
			return clut[0];
		end
		b = sprite_mem[lin >> 1];
		return clut[lin[0] ? b[3:0] : b[7:4]];
	endfunction

	function automatic pspb_out_t blit_result(input pspb_in_t r);
		pspb_out_t o;
		logic [15:0] c0;
		logic [15:0] c1;
		bit in0;
		bit in1;
		int col;
		int row;
		o = '0;
		col = int'(r.column);
		row = int'(r.row);
		case (r.req_type)
			REQ_LOAD_PIXEL: begin
				if (r.pixel_byte_addr < STORE_BYTES_DEF)
					sprite_mem[r.pixel_byte_addr] = r.pixel_byte;
			end
			REQ_LOAD_PALETTE: begin
				clut[r.palette_slot] = r.palette_color;
			end
			REQ_DRAW, REQ_SHADOW_DRAW: begin
				c0 = texel(col, row, in0);
				if (in0 && c0 != clut[0]) begin
					o.write_enable = 1'b1;
					o.color = (r.req_type == REQ_SHADOW_DRAW) ? shd_color : c0;
				end
			end
			REQ_MOVE_CLEAR: begin
				c0 = texel(col, row, in0);
				c1 = texel(col - int'(shift_x), row - int'(shift_y), in1);
				if (in0 && c0 != clut[0] && (!in1 || c1 == clut[0])) begin
					o.write_enable = 1'b1;
					o.color = clr_color;
				end
			end
			default: begin
			end
		endcase
		if (o.write_enable) begin
			o.screen_x = org_x + {9'd0, r.column};
			o.screen_y = org_y + {9'd0, r.row};
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w = 8'd1;
			img_h = 8'd1;
			org_x = '0;
			org_y = '0;
			shift_x = '0;
			shift_y = '0;
			clr_color = '0;
			shd_color = '0;
			expected_writes.delete();
			mismatches = 0;
			beats_checked = 0;
			writes_seen = 0;
			outstanding <= 0;
		end else begin
			if (res_valid && res_ready) begin
				beats_checked++;
				if (res.write_enable === 1'b1)
					writes_seen++;
				if (expected_writes.size() == 0) begin
					report_mismatch("unexpected result beat", res.color, 16'h0);
				end else begin
					want = expected_writes.pop_front();
					if (res.write_enable !== want.write_enable)
						report_mismatch("write_enable", {15'd0, res.write_enable},
							{15'd0, want.write_enable});
					if (res.screen_x !== want.screen_x)
						report_mismatch("screen_x", res.screen_x, want.screen_x);
					if (res.screen_y !== want.screen_y)
						report_mismatch("screen_y", res.screen_y, want.screen_y);
					if (res.color !== want.color)
						report_mismatch("color", res.color, want.color);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_IMAGE_WIDTH:  img_w = cfg_data[7:0];
					REG_IMAGE_HEIGHT: img_h = cfg_data[7:0];
					REG_ORIGIN_X:     org_x = cfg_data;
					REG_ORIGIN_Y:     org_y = cfg_data;
					REG_MOVE_DX:      shift_x = cfg_data;
					REG_MOVE_DY:      shift_y = cfg_data;
					REG_CLEAR_COLOR:  clr_color = cfg_data;
					REG_SHADOW_COLOR: shd_color = cfg_data;
					default: begin
					end
				endcase
			end
			if (req_valid && req_ready)
				expected_writes.push_back(blit_result(req));
			outstanding <= expected_writes.size();
		end
	end

endmodule

// File: bench/tb_palette_sprite_pixel_blit.sv
// testbench top: stimulus and verdict for the palette sprite blitter
`timescale 1ns / 1ps

module tb_palette_sprite_pixel_blit;
	import pspb_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	pspb_in_t    req;
	logic        res_valid;
	logic        res_ready = 1'b0;
	pspb_out_t   res;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	int mismatches;
	int outstanding;
	int beats_checked;
	int writes_seen;

	int src_idle = 0;
	int sink_stall = 0;
	int settings_run = 0;
	int cur_w = 1;
	int cur_h = 1;
	int cur_dx = 0;
	int cur_dy = 0;
	bit loaded [STORE_BYTES_DEF];
	logic [15:0] pal_copy [PALETTE_SIZE];

	palette_sprite_pixel_blit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	blit_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.req           (req),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res           (res),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.beats_checked (beats_checked),
		.writes_seen   (writes_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		res_ready <= ($urandom_range(99) >= sink_stall);
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic pspb_in_t rand_item();
		pspb_in_t it;
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		it = raw[$bits(pspb_in_t)-1:0];
		return it;
	endfunction

	task automatic send_req(input pspb_in_t item);
		while ($urandom_range(99) < src_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		if (item.req_type == REQ_LOAD_PIXEL)
			loaded[item.pixel_byte_addr] = 1'b1;
		if (item.req_type == REQ_LOAD_PALETTE)
			pal_copy[item.palette_slot] = item.palette_color;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// any pixel a query reads must sit in a byte that was loaded
	task automatic fill_byte_for(input int c, input int r);
		int lin;
		pspb_in_t it;
		if (c < 0 || r < 0 || c >= cur_w || r >= cur_h)
			return;
		lin = r * cur_w + c;
		if (!loaded[lin >> 1]) begin
			it = rand_item();
			it.req_type = REQ_LOAD_PIXEL;
			it.pixel_byte_addr = 13'(lin >> 1);
			send_req(it);
		end
	endtask

	task automatic query(input logic [2:0] kind, input int c, input int r);
		pspb_in_t it;
		fill_byte_for(c, r);
		if (kind == REQ_MOVE_CLEAR)
			fill_byte_for(c - cur_dx, r - cur_dy);
		it = rand_item();
		it.req_type = kind;
		it.column = 7'(c);
		it.row = 7'(r);
		send_req(it);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic setup(input int w, input int h, input logic [15:0] ox,
			input logic [15:0] oy, input logic [15:0] dx, input logic [15:0] dy,
			input logic [15:0] cc, input logic [15:0] sc);
		logic [7:0] junk;
		drain();
		junk = 8'($urandom);
		reg_write(REG_IMAGE_WIDTH, {junk, w[7:0]});
		junk = 8'($urandom);
		reg_write(REG_IMAGE_HEIGHT, {junk, h[7:0]});
		reg_write(REG_ORIGIN_X, ox);
		reg_write(REG_ORIGIN_Y, oy);
		reg_write(REG_MOVE_DX, dx);
		reg_write(REG_MOVE_DY, dy);
		reg_write(REG_CLEAR_COLOR, cc);
		reg_write(REG_SHADOW_COLOR, sc);
		cfg_we <= 1'b0;
		cur_w = (w > MAX_DIM_DEF) ? MAX_DIM_DEF : w;
		cur_h = (h > MAX_DIM_DEF) ? MAX_DIM_DEF : h;
		cur_dx = int'($signed(dx));
		cur_dy = int'($signed(dy));
		settings_run++;
	endtask

	task automatic burst(input int n, input int mode);
		pspb_in_t it;
		int roll;
		int c;
		int r;
		src_idle = (mode == 1) ? 52 : (mode == 3) ? 32 : 0;
		sink_stall = (mode == 2) ? 52 : (mode == 3) ? 32 : 0;
		for (int i = 0; i < n; i++) begin
			if (i == n / 2)
				drain();
			roll = $urandom_range(99);
			it = rand_item();
			if (roll < 8) begin
				it.req_type = REQ_LOAD_PIXEL;
				send_req(it);
			end else if (roll < 11) begin
				// half the palette reloads copy another slot, so transparency shifts
				it.req_type = REQ_LOAD_PALETTE;
				if ($urandom_range(1))
					it.palette_color = pal_copy[$urandom_range(15)];
				send_req(it);
			end else if (roll < 14) begin
				it.req_type = 3'($urandom_range(7, 5));
				send_req(it);
			end else begin
				c = ($urandom_range(9) < 8) ? $urandom_range(cur_w) : $urandom_range(127);
				r = ($urandom_range(9) < 8) ? $urandom_range(cur_h) : $urandom_range(127);
				if (c > 127)
					c = 127;
				if (r > 127)
					r = 127;
				query(roll < 40 ? REQ_DRAW : roll < 60 ? REQ_SHADOW_DRAW : REQ_MOVE_CLEAR, c, r);
			end
		end
	endtask

	initial begin
		pspb_in_t it;
		int sdx;
		int sdy;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// palette first: slot 0 and a duplicate of it are transparent
		for (int s = 0; s < PALETTE_SIZE; s++) begin
			it = rand_item();
			it.req_type = REQ_LOAD_PALETTE;
			it.palette_slot = 4'(s);
			it.palette_color = (s == 0 || s == 5) ? 16'h0000 :
				(s == 15) ? 16'hFFFF : 16'($urandom | 1);
			send_req(it);
		end
		it = rand_item();
		it.req_type = REQ_LOAD_PIXEL;
		it.pixel_byte_addr = 13'd0;
		it.pixel_byte = 8'hF5;
		send_req(it);
		it = rand_item();
		it.req_type = REQ_LOAD_PIXEL;
		it.pixel_byte_addr = 13'h1FFF;
		it.pixel_byte = 8'hA0;
		send_req(it);

		// reset geometry is one pixel at the screen origin
		query(REQ_DRAW, 0, 0);
		query(REQ_SHADOW_DRAW, 0, 0);
		query(REQ_MOVE_CLEAR, 0, 0);
		query(REQ_DRAW, 1, 0);
		for (int k = 5; k < 8; k++) begin
			it = rand_item();
			it.req_type = 3'(k);
			send_req(it);
		end

		// shifted pixel off the image uncovers, transparent duplicate stays quiet
		setup(2, 1, 16'h8000, 16'hFFFF, 16'd1, 16'd0, 16'hFFFF, 16'h0000);
		query(REQ_MOVE_CLEAR, 0, 0);
		query(REQ_MOVE_CLEAR, 1, 0);
		query(REQ_DRAW, 1, 0);

		// last bytes of the store, screen coordinates wrapping
		setup(128, 128, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h1234, 16'hFFFF);
		query(REQ_DRAW, 127, 127);
		query(REQ_DRAW, 126, 127);
		query(REQ_SHADOW_DRAW, 126, 127);
		query(REQ_MOVE_CLEAR, 126, 127);

		setup(8, 8, 16'd100, 16'd50, 16'd1, 16'd0, 16'($urandom), 16'($urandom));
		burst(200, 0);
		setup(128, 128, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'($urandom),
			16'($urandom));
		burst(150, 1);
		setup(255, 3, 16'h8000, 16'hFFFF, -16'sd2, 16'd1, 16'($urandom), 16'($urandom));
		burst(200, 2);
		setup(0, 5, 16'd7, 16'd7, 16'd0, 16'd0, 16'($urandom), 16'($urandom));
		burst(60, 3);
		setup(1, 128, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'($urandom), 16'($urandom));
		burst(200, 0);
		sdx = int'($urandom_range(8)) - 4;
		sdy = int'($urandom_range(8)) - 4;
		setup(16, 16, 16'($urandom), 16'($urandom), sdx[15:0], sdy[15:0],
			16'($urandom), 16'($urandom));
		burst(250, 1);
		setup(37, 200, -16'sd5, 16'd9, 16'd3, -16'sd4, 16'($urandom), 16'($urandom));
		burst(250, 2);
		setup(5, 0, 16'd0, 16'd0, 16'd1, 16'd1, 16'($urandom), 16'($urandom));
		burst(60, 3);
		setup(128, 128, -16'sd100, -16'sd100, 16'd2, 16'd2, 16'($urandom),
			16'($urandom));
		burst(200, 3);
		sdx = int'($urandom_range(32)) - 16;
		sdy = int'($urandom_range(32)) - 16;
		setup(12, 9, 16'($urandom), 16'($urandom), sdx[15:0], sdy[15:0],
			16'($urandom), 16'($urandom));
		burst(300, 1);
		burst(150, 0);

		drain();
		$display("run covered %0d register settings, %0d result beats checked, %0d pixel writes",
			settings_run, beats_checked, writes_seen);
		$display("draws, shadow draws and move clears under all idle and stall mixes");
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/core/pspb_pkg.sv
rtl/core/pspb_pixel_mem.sv
rtl/core/palette_sprite_pixel_blit.sv
bench/blit_checker.sv
bench/tb_palette_sprite_pixel_blit.sv
